// ----- rtl/cbez_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbez_pkg
// Shared widths, codes, reset values and arithmetic helpers of the cubic
// Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbez_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    localparam int COORD_W     = 24;
    localparam int WGT_W       = T_W + 2;
    localparam int PROD_W      = WGT_W + 1 + COORD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int NUM_PTS     = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_COORDS  = NUM_PTS * NUM_AXES;
    localparam int IDX_W       = $clog2(NUM_COORDS);
    localparam int WGT_STAGES  = 4;
    localparam int NUM_STAGES  = WGT_STAGES + 3;

    localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC_BITS;
    localparam logic [T_W-1:0] T_HALF = T_W'(1) << (T_FRAC_BITS - 1);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [T_W-1:0]     tval_t;
    typedef logic        [WGT_W-1:0]   wgt_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    // Control points (-2,0,0), (-0.5,1,0), (0.5,-1,0), (2,0,0) in Q8.16.
    localparam coord_t RESET_COORDS [NUM_COORDS] = '{
        -24'sd131072, 24'sd0,      24'sd0,
        -24'sd32768,  24'sd65536,  24'sd0,
        24'sd32768,   -24'sd65536, 24'sd0,
        24'sd131072,  24'sd0,      24'sd0
    };

    // Unsigned fixed-point product rounded to nearest.
    function automatic tval_t mul_rnd(input tval_t a, input tval_t b);
        logic [2*T_W:0] p;
        p = (2*T_W+1)'(a) * (2*T_W+1)'(b) + (2*T_W+1)'(T_HALF);
        return p[T_FRAC_BITS +: T_W];
    endfunction

    // Clamp a wide signed value to the coordinate range.
    function automatic coord_t sat_coord(input sum_t v);
        coord_t r;
        if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cbez_weights.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbez_weights
// Four-stage pipeline that turns the curve parameter into the four
// Bernstein weights.
// ----------------------------------------------------------------------------
module cbez_weights (
    input  wire logic                                aclk,
    input  wire logic [cbez_pkg::WGT_STAGES-1:0]     stage_en,
    input  wire cbez_pkg::tval_t                     param_t,
    output cbez_pkg::wgt_t                           wgt [cbez_pkg::NUM_PTS]
);
    import cbez_pkg::*;

    tval_t t0_reg, u0_reg;
    tval_t t1_reg, u1_reg, t2_reg, u2_reg;
    tval_t q_reg [NUM_PTS];
    wgt_t  w_reg [NUM_PTS];
    tval_t t_clamp;

    assign t_clamp = (param_t > T_ONE) ? T_ONE : param_t;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t0_reg <= t_clamp;
            u0_reg <= T_ONE - t_clamp;
        end
        if (stage_en[1]) begin
            t1_reg <= t0_reg;
            u1_reg <= u0_reg;
            t2_reg <= mul_rnd(t0_reg, t0_reg);
            u2_reg <= mul_rnd(u0_reg, u0_reg);
        end
        if (stage_en[2]) begin
            q_reg[0] <= mul_rnd(u2_reg, u1_reg);
            q_reg[1] <= mul_rnd(u2_reg, t1_reg);
            q_reg[2] <= mul_rnd(u1_reg, t2_reg);
            q_reg[3] <= mul_rnd(t2_reg, t1_reg);
        end
        if (stage_en[3]) begin
            w_reg[0] <= WGT_W'(q_reg[0]);
            w_reg[1] <= WGT_W'(q_reg[1]) + (WGT_W'(q_reg[1]) << 1);
            w_reg[2] <= WGT_W'(q_reg[2]) + (WGT_W'(q_reg[2]) << 1);
            w_reg[3] <= WGT_W'(q_reg[3]);
        end
    end

    assign wgt = w_reg;

endmodule
`default_nettype wire

// ----- rtl/cbez_axis.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbez_axis
// One axis of the evaluator: carries the item's control coordinates down
// the pipeline, multiplies them by the weights, sums, rounds and saturates.
// ----------------------------------------------------------------------------
module cbez_axis (
    input  wire logic                                aclk,
    input  wire logic [cbez_pkg::NUM_STAGES-1:0]     stage_en,
    input  wire cbez_pkg::coord_t                    pts [cbez_pkg::NUM_PTS],
    input  wire cbez_pkg::wgt_t                      wgt [cbez_pkg::NUM_PTS],
    output cbez_pkg::coord_t                         result
);
    import cbez_pkg::*;

    coord_t p_reg [WGT_STAGES][NUM_PTS];
    prod_t  prod_reg [NUM_PTS];
    logic signed [PROD_W:0] s01_reg, s23_reg;
    coord_t res_reg;
    sum_t   sum;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_PTS; k++) begin
            if (stage_en[0]) begin
                p_reg[0][k] <= pts[k];
            end
            for (int s = 1; s < WGT_STAGES; s++) begin
                if (stage_en[s]) begin
                    p_reg[s][k] <= p_reg[s-1][k];
                end
            end
            if (stage_en[WGT_STAGES]) begin
                prod_reg[k] <= $signed({1'b0, wgt[k]}) * p_reg[WGT_STAGES-1][k];
            end
        end
        if (stage_en[WGT_STAGES+1]) begin
            s01_reg <= (PROD_W+1)'(prod_reg[0]) + (PROD_W+1)'(prod_reg[1])
                     + (PROD_W+1)'(signed'({1'b0, T_HALF}));
            s23_reg <= (PROD_W+1)'(prod_reg[2]) + (PROD_W+1)'(prod_reg[3]);
        end
        if (stage_en[WGT_STAGES+2]) begin
            res_reg <= sat_coord(sum >>> T_FRAC_BITS);
        end
    end

    assign sum    = SUM_W'(s01_reg) + SUM_W'(s23_reg);
    assign result = res_reg;

endmodule
`default_nettype wire

// ----- rtl/cubic_bezier_point_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_evaluator
// Holds four 3D control points and evaluates the cubic Bezier curve at t.
//
//   Channel  Ports     Direction  Carries
//   input    s_*       in         load of one coordinate, or evaluate at t
//   result   m_*       out        one saturated curve point per evaluate
//
// An evaluate item passes seven register stages before its result is valid.
// An item can be accepted every cycle unless a stalled result has filled
// the pipeline, since each stage holds one item and passes it on whenever
// the stage after it has room.
// A load item takes effect for every evaluate accepted after it.
// Reset restores the default control points and empties the pipeline.
// A stalled result holds the pipeline; items behind it stay in place.
// ----------------------------------------------------------------------------
module cubic_bezier_point_evaluator (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_op,
    input  wire logic [1:0]               s_point_index,
    input  wire logic [1:0]               s_axis,
    input  wire cbez_pkg::coord_t         s_coord_value,
    input  wire cbez_pkg::tval_t          s_param_t,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output cbez_pkg::coord_t              m_point_x,
    output cbez_pkg::coord_t              m_point_y,
    output cbez_pkg::coord_t              m_point_z
);
    import cbez_pkg::*;

    coord_t coord_reg [NUM_COORDS];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   rdy;
    logic                  accept, eval_acc, load_acc;
    logic [IDX_W-1:0]      wr_idx;
    wgt_t                  wgt [NUM_PTS];
    coord_t                pts [NUM_AXES][NUM_PTS];
    coord_t                res [NUM_AXES];

    always_comb begin
        rdy[NUM_STAGES] = m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready  = rdy[0];
    assign accept   = s_valid && s_ready;
    assign eval_acc = accept && (s_op == OP_EVAL);
    assign load_acc = accept && (s_op == OP_LOAD) && (s_axis != AXIS_NONE);
    assign wr_idx   = IDX_W'(s_point_index) * IDX_W'(NUM_AXES) + IDX_W'(s_axis);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int i = 0; i < NUM_COORDS; i++) begin
                coord_reg[i] <= RESET_COORDS[i];
            end
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= (i == 0) ? eval_acc : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
            if (load_acc) begin
                coord_reg[wr_idx] <= s_coord_value;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int k = 0; k < NUM_PTS; k++) begin
                pts[a][k] = coord_reg[k*NUM_AXES + a];
            end
        end
    end

    cbez_weights u_weights (
        .aclk     (aclk),
        .stage_en (rdy[WGT_STAGES-1:0]),
        .param_t  (s_param_t),
        .wgt      (wgt)
    );

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        cbez_axis u_axis (
            .aclk     (aclk),
            .stage_en (rdy[NUM_STAGES-1:0]),
            .pts      (pts[a]),
            .wgt      (wgt),
            .result   (res[a])
        );
    end

    assign m_valid   = vld_reg[NUM_STAGES-1];
    assign m_point_x = res[AXIS_X];
    assign m_point_y = res[AXIS_Y];
    assign m_point_z = res[AXIS_Z];

    a_eval_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_acc |=> vld_reg[0])
        else $error("accepted evaluate item did not enter the pipeline");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_LOAD) |=> !vld_reg[0])
        else $error("load item entered the result pipeline");

    a_load_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |=> coord_reg[$past(wr_idx)] == $past(s_coord_value))
        else $error("load item did not update its control coordinate");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NUM_STAGES-1] && !m_ready) |=> vld_reg[NUM_STAGES-1]
            && $stable(m_point_x) && $stable(m_point_y) && $stable(m_point_z))
        else $error("stalled result was lost or changed");

endmodule
`default_nettype wire
